// File: design/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: design/hexp_pkg.sv
// Types, character codes and decode helpers for the hex text parser
package hexp_pkg;

  localparam int CHAR_W   = 8;
  localparam int COUNT_W  = 16;
  localparam int NIBBLE_W = 4;
  localparam int TDATA_W  = 32;
  localparam int PAD_W    = TDATA_W - CHAR_W - 1 - COUNT_W;

  localparam logic [COUNT_W-1:0] MAX_BYTES_RST = 16'hFFFF;

  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h66;
  localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UF    = 8'h46;
  localparam logic [CHAR_W-1:0] DIGIT_TEN  = 8'd10;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              is_end;
  } item_t;

  typedef struct packed {
    logic               result_kind;
    logic [CHAR_W-1:0]  data_byte;
    logic               failed;
    logic [COUNT_W-1:0] byte_count;
  } result_t;

  // handshake from the core, seen by the input and output stages
  typedef struct packed {
    logic fire;
  } flow_t;

  function automatic logic is_blank(input logic [CHAR_W-1:0] ch);
    return ((ch >= CHAR_TAB) && (ch <= CHAR_CR)) || (ch == CHAR_SPACE);
  endfunction

  function automatic logic is_sep(input logic [CHAR_W-1:0] ch);
    return (ch == CHAR_COLON) || (ch == CHAR_DASH) || (ch == CHAR_COMMA);
  endfunction

  // bit 4 set means not a hex digit
  function automatic logic [NIBBLE_W:0] digit_value(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] v;
    v = '0;
    if ((ch >= CHAR_0) && (ch <= CHAR_9)) begin
      v = ch - CHAR_0;
      return {1'b0, v[NIBBLE_W-1:0]};
    end else if ((ch >= CHAR_LA) && (ch <= CHAR_LF)) begin
      v = ch - CHAR_LA + DIGIT_TEN;
      return {1'b0, v[NIBBLE_W-1:0]};
    end else if ((ch >= CHAR_UA) && (ch <= CHAR_UF)) begin
      v = ch - CHAR_UA + DIGIT_TEN;
      return {1'b0, v[NIBBLE_W-1:0]};
    end
    return {1'b1, {NIBBLE_W{1'b0}}};
  endfunction

endpackage

// File: design/hexp_in_stage.sv
// Input register: holds one accepted character item until the core takes it
module hexp_in_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [hexp_pkg::CHAR_W-1:0] in_tdata,
  input  logic                       in_tlast,
  input  logic                       take,
  output logic                       item_valid,
  output hexp_pkg::item_t            item
);

  logic            valid_r;
  logic            valid_nxt;
  hexp_pkg::item_t item_r;
  hexp_pkg::item_t item_nxt;
  logic            accept;

  assign in_tready = !valid_r || take;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (accept) begin
      valid_nxt          = 1'b1;
      item_nxt.char_code = in_tdata;
      item_nxt.is_end    = in_tlast;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: design/hexp_core.sv
// Parse state, byte limit register and per-character decode
module hexp_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [hexp_pkg::COUNT_W-1:0]  cfg_wr_data,
  input  logic                          item_valid,
  input  hexp_pkg::item_t               item,
  input  logic                          out_space,
  output hexp_pkg::flow_t               flow,
  output logic                          res_valid,
  output hexp_pkg::result_t             res
);

  logic [hexp_pkg::COUNT_W-1:0]  max_bytes_r;
  logic [hexp_pkg::COUNT_W-1:0]  max_bytes_nxt;
  logic                          awaiting_low_r;
  logic                          awaiting_low_nxt;
  logic [hexp_pkg::NIBBLE_W-1:0] held_r;
  logic [hexp_pkg::NIBBLE_W-1:0] held_nxt;
  logic [hexp_pkg::COUNT_W-1:0]  bytes_done_r;
  logic [hexp_pkg::COUNT_W-1:0]  bytes_done_nxt;
  logic                          error_r;
  logic                          error_nxt;
  logic                          fire;
  logic                          blank;
  logic                          sep;
  logic [hexp_pkg::NIBBLE_W:0]   dv;
  logic                          bad;

  assign fire       = item_valid && out_space;
  assign flow.fire  = fire;
  assign blank      = hexp_pkg::is_blank(item.char_code);
  assign sep        = hexp_pkg::is_sep(item.char_code);
  assign dv         = hexp_pkg::digit_value(item.char_code);
  assign bad        = error_r || awaiting_low_r;

  assign max_bytes_nxt = cfg_wr_en ? cfg_wr_data : max_bytes_r;

  always_comb begin
    awaiting_low_nxt = awaiting_low_r;
    held_nxt         = held_r;
    bytes_done_nxt   = bytes_done_r;
    error_nxt        = error_r;
    res_valid        = 1'b0;
    res              = '0;
    if (fire) begin
      if (item.is_end) begin
        res_valid        = 1'b1;
        res.result_kind  = hexp_pkg::KIND_STATUS;
        res.failed       = bad;
        res.byte_count   = bad ? '0 : bytes_done_r;
        awaiting_low_nxt = 1'b0;
        held_nxt         = '0;
        bytes_done_nxt   = '0;
        error_nxt        = 1'b0;
      end else if (!error_r) begin
        if (!awaiting_low_r) begin
          if (!(blank || sep)) begin
            if (dv[hexp_pkg::NIBBLE_W]) begin
              error_nxt = 1'b1;
            end else begin
              held_nxt         = dv[hexp_pkg::NIBBLE_W-1:0];
              awaiting_low_nxt = 1'b1;
            end
          end
        end else if (!blank) begin
          awaiting_low_nxt = 1'b0;
          if (dv[hexp_pkg::NIBBLE_W] || (bytes_done_r >= max_bytes_r)) begin
            error_nxt = 1'b1;
          end else begin
            bytes_done_nxt  = bytes_done_r + 1'b1;
            res_valid       = 1'b1;
            res.result_kind = hexp_pkg::KIND_BYTE;
            res.data_byte   = {held_r, dv[hexp_pkg::NIBBLE_W-1:0]};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r    <= hexp_pkg::MAX_BYTES_RST;
      awaiting_low_r <= 1'b0;
      held_r         <= '0;
      bytes_done_r   <= '0;
      error_r        <= 1'b0;
    end else begin
      max_bytes_r    <= max_bytes_nxt;
      awaiting_low_r <= awaiting_low_nxt;
      held_r         <= held_nxt;
      bytes_done_r   <= bytes_done_nxt;
      error_r        <= error_nxt;
    end
  end

endmodule

// File: design/hexp_out_stage.sv
// Result register driving the output stream
module hexp_out_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hexp_pkg::flow_t               flow,
  input  logic                          res_valid,
  input  hexp_pkg::result_t             res,
  output logic                          space,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [hexp_pkg::TDATA_W-1:0]  out_tdata,
  output logic                          out_tuser
);

  logic              valid_r;
  logic              valid_nxt;
  hexp_pkg::result_t res_r;
  hexp_pkg::result_t res_nxt;
  logic              load;

  assign space = !valid_r || out_tready;
  assign load  = flow.fire && res_valid;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.result_kind;
  assign out_tdata  = {{hexp_pkg::PAD_W{1'b0}}, res_r.byte_count, res_r.failed,
                       res_r.data_byte};

endmodule

// File: design/hex_text_to_bytes_parser.sv
// Top level of the hex text to bytes parser
//
// Input stream: one ASCII character per item in in_tdata, in_tlast high marks
// the terminator item (its character is ignored). Output stream: one decoded
// byte per completed hex pair (out_tuser 0), and one status item per
// terminator (out_tuser 1) carrying the failed flag and the byte count.
// Configuration: cfg_wr_data is written to the byte limit when cfg_wr_en is
// high; write it only while the block is idle. The limit resets to 65535.
// Path: an item accepted into the input register is decoded into the result
// register once the result register has space, and its result is taken from
// there. Throughput is one item per cycle while the receiver does not stall,
// set by the single decode step between the two registers.
// Items that give no result (skipped characters, the high nibble, errors)
// still need space in the result register to pass, but do not touch the output.
// Reset clears the parse state and the valid flags of both registers; a
// terminator also clears the parse state. On a receiver stall the result
// register holds; the input register fills if empty, then in_tready drops.
module hex_text_to_bytes_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [hexp_pkg::CHAR_W-1:0]   in_tdata,   // [7:0] char_code
  input  logic                          in_tlast,   // is_end
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [7:0] data_byte, [8] failed, [24:9] byte_count, [31:25] zero
  output logic [hexp_pkg::TDATA_W-1:0]  out_tdata,
  output logic                          out_tuser,  // result_kind
  input  logic                          cfg_wr_en,
  input  logic [hexp_pkg::COUNT_W-1:0]  cfg_wr_data
);

  logic              item_valid;
  hexp_pkg::item_t   item;
  hexp_pkg::flow_t   flow;
  logic              res_valid;
  hexp_pkg::result_t res;
  logic              space;

  hexp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .take       (flow.fire),
    .item_valid (item_valid),
    .item       (item)
  );

  hexp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (item_valid),
    .item        (item),
    .out_space   (space),
    .flow        (flow),
    .res_valid   (res_valid),
    .res         (res)
  );

  hexp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .flow       (flow),
    .res_valid  (res_valid),
    .res        (res),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: design/hexp_checker.sv
// Port-level checks on the parser output, bound to the top level
`include "assert_macros.svh"

module hexp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [hexp_pkg::TDATA_W-1:0]  out_tdata,
  input logic                          out_tuser
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `ASSERT_IMPLIES(a_status_no_byte, clk, rst_n, out_tvalid && out_tuser, out_tdata[7:0] == 8'd0)
  `ASSERT_IMPLIES(a_byte_no_status, clk, rst_n, out_tvalid && !out_tuser, !out_tdata[8] && (out_tdata[24:9] == 16'd0))
  `ASSERT_IMPLIES(a_fail_zero_count, clk, rst_n, out_tvalid && out_tuser && out_tdata[8], out_tdata[24:9] == 16'd0)
  `ASSERT_IMPLIES(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[31:25] == 7'd0)

endmodule

bind hex_text_to_bytes_parser hexp_checker u_hexp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: tb/tb_hex_text_to_bytes_parser.sv
// Self-checking testbench for the hex text to bytes parser: queued characters in, results checked
`timescale 1ns / 1ps

module tb_hex_text_to_bytes_parser;

  localparam int IDLE_PCT = 13;

  logic                          clk         = 1'b0;
  logic                          rst_n       = 1'b0;
  logic                          in_tvalid   = 1'b0;
  logic                          in_tready;
  logic [hexp_pkg::CHAR_W-1:0]   in_tdata    = '0;    // [7:0] char_code
  logic                          in_tlast    = 1'b0;  // is_end
  logic                          out_tvalid;
  logic                          out_tready  = 1'b0;
  // [7:0] data_byte, [8] failed, [24:9] byte_count
  logic [hexp_pkg::TDATA_W-1:0]  out_tdata;
  logic                          out_tuser;           // result_kind
  logic                          cfg_wr_en   = 1'b0;
  logic [hexp_pkg::COUNT_W-1:0]  cfg_wr_data = '0;

  hex_text_to_bytes_parser i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  hexp_pkg::item_t   char_items[$];
  hexp_pkg::result_t expected_results[$];
  hexp_pkg::item_t   head_item;
  hexp_pkg::result_t fresh_result;
  hexp_pkg::result_t seen_result;
  logic    in_took = 1'b0;
  logic    calm = 1'b0;
  int      mismatches = 0;
  int      chars_queued = 0;

  // parser shadow state
  logic                         waiting_low = 1'b0;
  logic [3:0]                   high_nib    = '0;
  logic [hexp_pkg::COUNT_W-1:0] byte_tally  = '0;
  logic                         fault       = 1'b0;
  logic [hexp_pkg::COUNT_W-1:0] limit_reg   = hexp_pkg::MAX_BYTES_RST;

  function automatic logic is_space_char(input logic [7:0] c);
    return (c >= hexp_pkg::CHAR_TAB && c <= hexp_pkg::CHAR_CR) || c == hexp_pkg::CHAR_SPACE;
  endfunction

  function automatic logic is_filler(input logic [7:0] c);
    return is_space_char(c) || c == hexp_pkg::CHAR_COLON || c == hexp_pkg::CHAR_DASH ||
           c == hexp_pkg::CHAR_COMMA;
  endfunction

  // bit 4 flags a non-digit; folding to lower case covers both letter cases
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [7:0] low_c;
    logic [3:0] n;
    low_c = c | 8'h20;
    n = c[3:0] + 4'd9;
    if (c >= hexp_pkg::CHAR_0 && c <= hexp_pkg::CHAR_9) return {1'b0, c[3:0]};
    if (low_c >= hexp_pkg::CHAR_LA && low_c <= hexp_pkg::CHAR_LF) return {1'b0, n};
    return 5'h10;
  endfunction

  function automatic logic step_parser(input logic [7:0] c, input logic term,
                                       output hexp_pkg::result_t r);
    logic [4:0] nib;
    logic       bad;
    r = '0;
    nib = nibble_of(c);
    if (term) begin
      bad = fault || waiting_low;
      r.result_kind = hexp_pkg::KIND_STATUS;
      r.failed      = bad;
      r.byte_count  = bad ? '0 : byte_tally;
      waiting_low = 1'b0;
      high_nib    = '0;
      byte_tally  = '0;
      fault       = 1'b0;
      return 1'b1;
    end
    if (fault) return 1'b0;
    if (!waiting_low) begin
      if (is_filler(c)) return 1'b0;
      if (nib[4]) begin
        fault = 1'b1;
        return 1'b0;
      end
      high_nib = nib[3:0];
      waiting_low = 1'b1;
      return 1'b0;
    end
    if (is_space_char(c)) return 1'b0;
    waiting_low = 1'b0;
    // a pair completed at the limit is an overflow, not a byte
    if (nib[4] || byte_tally >= limit_reg) begin
      fault = 1'b1;
      return 1'b0;
    end
    byte_tally = byte_tally + 1'b1;
    r.result_kind = hexp_pkg::KIND_BYTE;
    r.data_byte   = {high_nib, nib[3:0]};
    return 1'b1;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (!in_tvalid || in_took) begin
        if (char_items.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          head_item = char_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= head_item.char_code;
          in_tlast  <= head_item.is_end;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // monitor: check the result first, then predict from the accepted item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        seen_result.result_kind = out_tuser;
        seen_result.data_byte   = out_tdata[7:0];
        seen_result.failed      = out_tdata[8];
        seen_result.byte_count  = out_tdata[24:9];
        if (expected_results.size() == 0) begin
          if (mismatches < 40)
            $display("%0t: result with nothing expected: kind %0b byte %02h failed %0b count %0d",
                     $time, out_tuser, out_tdata[7:0], out_tdata[8], out_tdata[24:9]);
          mismatches++;
        end else begin
          fresh_result = expected_results.pop_front();
          if (seen_result !== fresh_result || out_tdata[31:25] !== '0) begin
            if (mismatches < 40)
              $display({"%0t: mismatch: expected kind %0b byte %02h failed %0b count %0d,",
                        " got kind %0b byte %02h failed %0b count %0d pad %02h"},
                       $time, fresh_result.result_kind, fresh_result.data_byte,
                       fresh_result.failed, fresh_result.byte_count,
                       seen_result.result_kind, seen_result.data_byte,
                       seen_result.failed, seen_result.byte_count, out_tdata[31:25]);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (step_parser(in_tdata, in_tlast, fresh_result))
          expected_results.push_back(fresh_result);
      end
    end
  end

  task automatic push_char(input logic [7:0] c);
    hexp_pkg::item_t it;
    it.char_code = c;
    it.is_end = 1'b0;
    char_items.push_back(it);
    chars_queued++;
  endtask

  task automatic push_end(input logic [7:0] c);
    hexp_pkg::item_t it;
    it.char_code = c;
    it.is_end = 1'b1;
    char_items.push_back(it);
    chars_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  function automatic logic [7:0] digit_char(input int v);
    if (v < 10) return hexp_pkg::CHAR_0 + 8'(v);
    if ($urandom_range(1)) return hexp_pkg::CHAR_UA + 8'(v - 10);
    return hexp_pkg::CHAR_LA + 8'(v - 10);
  endfunction

  function automatic logic [7:0] pick_blank();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? hexp_pkg::CHAR_SPACE : hexp_pkg::CHAR_TAB + 8'(r);
  endfunction

  function automatic logic [7:0] pick_filler();
    int r;
    r = $urandom_range(8);
    if (r == 6) return hexp_pkg::CHAR_COLON;
    if (r == 7) return hexp_pkg::CHAR_DASH;
    if (r == 8) return hexp_pkg::CHAR_COMMA;
    return pick_blank();
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    logic [4:0] n;
    c = 8'($urandom_range(255));
    n = nibble_of(c);
    while (!n[4] || is_filler(c)) begin
      c = 8'($urandom_range(255));
      n = nibble_of(c);
    end
    return c;
  endfunction

  // mostly well-formed strings; some raw noise, some with a defect at the tail
  task automatic push_frame();
    int kind;
    int pairs;
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 10)) push_char(8'($urandom_range(255)));
    end else begin
      pairs = $urandom_range(0, 8);
      for (int p = 0; p < pairs; p++) begin
        repeat ($urandom_range(0, 2)) push_char(pick_filler());
        push_char(digit_char($urandom_range(15)));
        if ($urandom_range(3) == 0) push_char(pick_blank());
        push_char(digit_char($urandom_range(15)));
      end
      if (kind < 24) begin
        case ($urandom_range(2))
          0: push_char(digit_char($urandom_range(15)));
          1: begin
            if ($urandom_range(1)) push_char(digit_char($urandom_range(15)));
            push_char(bad_char());
            push_char(digit_char($urandom_range(15)));
            push_char(digit_char($urandom_range(15)));
          end
          default: begin
            push_char(digit_char($urandom_range(15)));
            push_char(pick_filler());
            push_char(digit_char($urandom_range(15)));
          end
        endcase
      end
    end
    push_end(8'($urandom_range(255)));
  endtask

  task automatic run_random(input int n);
    chars_queued = 0;
    while (chars_queued < n) push_frame();
  endtask

  // idle, plus a wait for items still inside that give no result
  task automatic wait_idle();
    while (char_items.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_limit(input logic [hexp_pkg::COUNT_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    limit_reg = v;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // separators before the high nibble, mixed case, blank inside a pair
    push_text(":-,\t0f");
    push_text("A \nb");
    push_text("9e");
    push_end(8'hFF);
    // bad low digit, then the rest of the string is ignored
    push_text("3g12");
    push_end(8'h00);
    // terminator right after a high nibble
    push_text("5");
    push_end(8'h35);
    // top-bit character where a digit is due
    push_char(8'hFF);
    push_end(8'h80);
    // separator between the nibbles
    push_text("7:");
    push_end(8'h00);
    run_random(230);
    wait_idle();

    write_limit(16'd0);
    push_text("00");
    push_end(8'h00);
    run_random(150);
    wait_idle();

    write_limit(16'd1);
    run_random(150);
    wait_idle();

    calm = 1'b1;
    write_limit(16'd3);
    run_random(200);
    wait_idle();
    calm = 1'b0;

    write_limit(16'($urandom_range(2, 10)));
    run_random(150);
    wait_idle();

    write_limit(16'($urandom_range(65535)));
    run_random(150);
    wait_idle();

    write_limit(16'hFFFF);
    run_random(100);
    wait_idle();

    if (mismatches == 0) begin
      $display("tb_hex_text_to_bytes_parser: done, clean");
    end else begin
      $display("tb_hex_text_to_bytes_parser: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_hex_text_to_bytes_parser: done, errors");
    $finish;
  end

endmodule
